### design/leb_pkg.sv
// ----------------------------------------------------------------------------
// leb_pkg
// Shared types and key codes for the line edit buffer.
// ----------------------------------------------------------------------------
package leb_pkg;

  localparam int CharW = 8;

  localparam logic [CharW-1:0] KEY_BACK  = 8'h42;
  localparam logic [CharW-1:0] KEY_LEFT  = 8'h4C;
  localparam logic [CharW-1:0] KEY_RIGHT = 8'h52;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOVE,
    ST_SHOW
  } leb_state_t;

  typedef enum logic {
    DIR_LEFT,
    DIR_RIGHT
  } leb_dir_t;

  typedef struct packed {
    logic [CharW-1:0] text_char;
    logic             char_valid;
    logic             last;
    logic             overflow;
  } leb_result_t;

endpackage

### design/leb_ram.sv
// ----------------------------------------------------------------------------
// leb_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module leb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### design/leb_ctrl.sv
// ----------------------------------------------------------------------------
// leb_ctrl
// Gap buffer sequencer: length, cursor and overflow registers, RAM access
// for edits and cursor moves, and the read walk of a show.
// ----------------------------------------------------------------------------
module leb_ctrl #(
  parameter int CAPACITY = 64,
  parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  parameter int LW       = $clog2(CAPACITY + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [leb_pkg::CharW-1:0] key,
  output logic                      ram_wr_en,
  output logic [AW-1:0]             ram_wr_addr,
  output logic [leb_pkg::CharW-1:0] ram_wr_data,
  output logic                      ram_rd_en,
  output logic [AW-1:0]             ram_rd_addr,
  input  logic [leb_pkg::CharW-1:0] ram_rd_data,
  input  logic                      out_ready,
  output logic                      res_load,
  output leb_pkg::leb_result_t      res
);
  import leb_pkg::*;

  localparam logic [LW-1:0] CapL = LW'(CAPACITY);
  localparam logic [LW-1:0] OneL = LW'(1);

  leb_state_t state, state_next;
  leb_dir_t   dir, dir_next;
  logic [LW-1:0] len, len_next;
  logic [LW-1:0] cur, cur_next;
  logic [LW-1:0] idx, idx_next;
  logic          ovf, ovf_next;
  logic          pend, pend_next;
  logic          pend_last, pend_last_next;

  logic [LW-1:0] gap;
  logic [LW-1:0] rd_pos;
  logic [LW-1:0] wr_pos;
  logic          accept;
  logic          is_edit, is_back, is_left, is_right;
  logic          show_issue;
  logic          show_done;

  assign gap     = CapL - len;
  assign accept  = in_valid && !in_stall;
  assign is_edit = !command;
  assign is_back  = is_edit && (key == KEY_BACK);
  assign is_left  = is_edit && (key == KEY_LEFT);
  assign is_right = is_edit && (key == KEY_RIGHT);

  // a read can go out when rd_data will be free by the next edge
  assign show_issue = (len != '0) && (idx != len) && (!pend || out_ready);
  assign show_done  = (len == '0) ? out_ready : ((idx == len) && (!pend || out_ready));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (command) begin
            state_next = ST_SHOW;
          end else if (is_left && cur != '0) begin
            state_next = ST_MOVE;
          end else if (is_right && cur != len) begin
            state_next = ST_MOVE;
          end
        end
      end
      ST_MOVE: state_next = ST_IDLE;
      ST_SHOW: begin
        if (show_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_stall       = rst || (state != ST_IDLE);
    ram_wr_en      = 1'b0;
    wr_pos         = cur;
    ram_wr_data    = key;
    ram_rd_en      = 1'b0;
    rd_pos         = cur;
    res_load       = 1'b0;
    res.text_char  = ram_rd_data;
    res.char_valid = 1'b1;
    res.last       = pend_last;
    res.overflow   = ovf;
    len_next       = len;
    cur_next       = cur;
    idx_next       = idx;
    ovf_next       = ovf;
    dir_next       = dir;
    pend_next      = pend;
    pend_last_next = pend_last;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          idx_next  = '0;
          pend_next = 1'b0;
          if (!command) begin
            if (is_back) begin
              // in a gap buffer a delete just widens the gap
              if (cur != '0) begin
                cur_next = cur - OneL;
                len_next = len - OneL;
              end
            end else if (is_left) begin
              if (cur != '0) begin
                ram_rd_en = 1'b1;
                rd_pos    = cur - OneL;
                dir_next  = DIR_LEFT;
              end
            end else if (is_right) begin
              if (cur != len) begin
                ram_rd_en = 1'b1;
                rd_pos    = gap + cur;
                dir_next  = DIR_RIGHT;
              end
            end else if (len == CapL) begin
              ovf_next = 1'b1;
            end else begin
              ram_wr_en = 1'b1;
              wr_pos    = cur;
              cur_next  = cur + OneL;
              len_next  = len + OneL;
            end
          end
        end
      end
      ST_MOVE: begin
        ram_wr_en   = 1'b1;
        ram_wr_data = ram_rd_data;
        if (dir == DIR_LEFT) begin
          // char left of the cursor goes to just below the gap end
          wr_pos   = gap + cur - OneL;
          cur_next = cur - OneL;
        end else begin
          wr_pos   = cur;
          cur_next = cur + OneL;
        end
      end
      ST_SHOW: begin
        if (len == '0) begin
          res_load       = out_ready;
          res.text_char  = '0;
          res.char_valid = 1'b0;
          res.last       = 1'b1;
        end else begin
          res_load = pend && out_ready;
          if (show_issue) begin
            ram_rd_en      = 1'b1;
            rd_pos         = (idx >= cur) ? idx + gap : idx;
            idx_next       = idx + OneL;
            pend_last_next = ((idx + OneL) == len);
          end
          pend_next = show_issue || (pend && !out_ready);
        end
        if (show_done) begin
          len_next = '0;
          cur_next = '0;
          ovf_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign ram_wr_addr = wr_pos[AW-1:0];
  assign ram_rd_addr = rd_pos[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      len       <= '0;
      cur       <= '0;
      ovf       <= 1'b0;
      pend      <= 1'b0;
      idx       <= '0;
      dir       <= DIR_LEFT;
      pend_last <= 1'b0;
    end else begin
      state     <= state_next;
      len       <= len_next;
      cur       <= cur_next;
      ovf       <= ovf_next;
      pend      <= pend_next;
      idx       <= idx_next;
      dir       <= dir_next;
      pend_last <= pend_last_next;
    end
  end

endmodule

### design/leb_out_reg.sv
// ----------------------------------------------------------------------------
// leb_out_reg
// Output register of the result channel; frees the sequencer from the stall.
// ----------------------------------------------------------------------------
module leb_out_reg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      res_load,
  input  leb_pkg::leb_result_t      res,
  output logic                      out_ready,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [leb_pkg::CharW-1:0] text_char,
  output logic                      char_valid,
  output logic                      last,
  output logic                      overflow
);
  import leb_pkg::*;

  leb_result_t hold;

  assign out_ready  = !out_valid || !out_stall;
  assign text_char  = hold.text_char;
  assign char_valid = hold.char_valid;
  assign last       = hold.last;
  assign overflow   = hold.overflow;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      hold <= res;
    end
  end

endmodule

### design/line_edit_buffer.sv
// ----------------------------------------------------------------------------
// line_edit_buffer
// Bounded line editor with a cursor, kept as a gap buffer in one RAM.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): command 0 applies keystroke key at the
// cursor ('B' backspace, 'L' left, 'R' right, anything else inserts);
// command 1 shows the text and then clears it.
// Text left of the cursor sits at the bottom of the RAM, text right of it at
// the top; the gap between them is the free space.
// Insert and backspace finish in idle; left and right move one character
// across the gap with a read then a write. The input stalls
// while a move or a show is in progress.
// A show streams one result per character on the output channel
// (out_valid/out_stall), last marking the final one; an empty buffer gives one
// result with char_valid low. Each character is read from the RAM, whose
// read is registered, and then loaded into the output register; the input
// stays stalled until the show returns to idle.
// Results pass through an output register, so a stall on the output holds the
// current result and pauses the read walk without losing data.
// Reset empties the buffer, puts the cursor at the start and clears overflow;
// the RAM itself is not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module line_edit_buffer #(
  parameter int CAPACITY = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      command,
  input  logic [leb_pkg::CharW-1:0] key,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [leb_pkg::CharW-1:0] text_char,
  output logic                      char_valid,
  output logic                      last,
  output logic                      overflow
);
  import leb_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);

  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [CharW-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [CharW-1:0] ram_rd_data;
  logic             out_ready;
  logic             res_load;
  leb_result_t      res;

  leb_ram #(
    .WIDTH (CharW),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  leb_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .LW       (LW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .command     (command),
    .key         (key),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .out_ready   (out_ready),
    .res_load    (res_load),
    .res         (res)
  );

  leb_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .res_load   (res_load),
    .res        (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .text_char  (text_char),
    .char_valid (char_valid),
    .last       (last),
    .overflow   (overflow)
  );

endmodule

### design/leb_checker.sv
// ----------------------------------------------------------------------------
// leb_checker
// Port-level checks of the line edit buffer, bound to the top level.
// ----------------------------------------------------------------------------
module leb_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_stall,
  input logic                      command,
  input logic [leb_pkg::CharW-1:0] key,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic [leb_pkg::CharW-1:0] text_char,
  input logic                      char_valid,
  input logic                      last,
  input logic                      overflow
);
  import leb_pkg::*;

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(text_char) && $stable(char_valid)
      && $stable(last) && $stable(overflow))
    else $error("stalled result changed");

  // the empty-buffer result is marked last and carries a zero character
  a_empty_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !char_valid |-> last && (text_char == '0))
    else $error("empty result not final or nonzero");

  // a show stalls the input in the cycle after it is taken
  a_show_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && command |=> in_stall)
    else $error("input taken right after show");

  // input is held off during reset
  a_rst_stall: assert property (@(posedge clk)
    rst |-> in_stall)
    else $error("input open during reset");

endmodule

bind line_edit_buffer leb_checker u_leb_checker (.*);
